FILE: rtl/sbol_pkg.sv
// ----------------------------------------------------------------------------
// Sweep baseline object locator package
// Shared widths, reset values, register indexes, state and interface types.
// ----------------------------------------------------------------------------
package sbol_pkg;

    localparam int ANGLE_W    = 8;
    localparam int RANGE_W    = 8;
    localparam int SAMPLE_W   = 12;
    localparam int THR_W      = 8;
    localparam int SCALE_W    = 17;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int COUNT_W    = 9;
    localparam int SUM_W      = 24;
    localparam int HIT_W      = 16;
    localparam int DVD_W      = SUM_W;
    localparam int DVS_W      = 17;

    localparam int DEF_HALF_SPAN       = 90;
    localparam int DEF_CALIBRATE_STEPS = 363;
    localparam int DEF_DETECT_STEPS    = 181;

    localparam logic [THR_W-1:0]   RST_THRESHOLD = 8'd30;
    localparam logic [RANGE_W-1:0] RST_MAX_DIST  = 8'd150;
    localparam logic [SCALE_W-1:0] RST_SCALE     = 17'd77504;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_CONV_WAIT,
        ST_EVAL,
        ST_END,
        ST_AVGA,
        ST_AVGA_WAIT,
        ST_AVGR,
        ST_AVGR_WAIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic capture;
        logic conv_start;
        logic eval;
        logic end_check;
        logic ang_start;
        logic ang_take;
        logic rng_start;
        logic rng_take;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic need_avg;
    } status_t;

endpackage

FILE: rtl/sbol_divider.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle, done pulse on completion.
// ----------------------------------------------------------------------------
module sbol_divider
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sbol_pkg::DVD_W-1:0]  dividend,
    input  logic [sbol_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [sbol_pkg::DVD_W-1:0]  quotient
);

    localparam int DVD_W = sbol_pkg::DVD_W;
    localparam int DVS_W = sbol_pkg::DVS_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             ge;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DVD_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = shifted >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                cnt_reg <= CNT_W'(DVD_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/sbol_datapath.sv
// ----------------------------------------------------------------------------
// Sweep baseline object locator datapath
// Configuration, sweep state, baseline memory, divider and result registers.
// ----------------------------------------------------------------------------
module sbol_datapath
#(
    parameter int HALF_SPAN       = sbol_pkg::DEF_HALF_SPAN,
    parameter int CALIBRATE_STEPS = sbol_pkg::DEF_CALIBRATE_STEPS,
    parameter int DETECT_STEPS    = sbol_pkg::DEF_DETECT_STEPS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [sbol_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sbol_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic                                  mode,
    input  logic                                  start_sweep,
    input  logic [sbol_pkg::SAMPLE_W-1:0]         sample,
    input  sbol_pkg::cmd_t                        cmd,
    output sbol_pkg::status_t                     status,
    output logic signed [sbol_pkg::ANGLE_W-1:0]   motor_angle,
    output logic [sbol_pkg::RANGE_W-1:0]          range_value,
    output logic                                  object_seen,
    output logic                                  bad_sample,
    output logic                                  sweep_done,
    output logic signed [sbol_pkg::ANGLE_W-1:0]   avg_angle,
    output logic [sbol_pkg::RANGE_W-1:0]          avg_range,
    output logic                                  none_found
);

    localparam int ANGLE_W     = sbol_pkg::ANGLE_W;
    localparam int RANGE_W     = sbol_pkg::RANGE_W;
    localparam int COUNT_W     = sbol_pkg::COUNT_W;
    localparam int SUM_W       = sbol_pkg::SUM_W;
    localparam int HIT_W       = sbol_pkg::HIT_W;
    localparam int DVD_W       = sbol_pkg::DVD_W;
    localparam int DVS_W       = sbol_pkg::DVS_W;
    localparam int STORE_DEPTH = 2 * HALF_SPAN + 1;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int OFS_W       = ANGLE_W + 2;

    localparam logic signed [ANGLE_W-1:0] ANG_MAX  = ANGLE_W'(HALF_SPAN);
    localparam logic signed [ANGLE_W-1:0] ANG_MIN  = ANGLE_W'(-HALF_SPAN);
    localparam logic [COUNT_W-1:0]        CAL_END  = COUNT_W'(CALIBRATE_STEPS);
    localparam logic [COUNT_W-1:0]        DET_END  = COUNT_W'(DETECT_STEPS);
    localparam logic signed [OFS_W-1:0]   OFS_HALF = OFS_W'(HALF_SPAN);
    localparam logic signed [OFS_W-1:0]   OFS_TOP  = OFS_W'(2 * HALF_SPAN);

    logic [sbol_pkg::THR_W-1:0]   thr_reg;
    logic [RANGE_W-1:0]           maxd_reg;
    logic [sbol_pkg::SCALE_W-1:0] scale_reg;

    logic                         mode_reg;
    logic [sbol_pkg::SAMPLE_W-1:0] sample_reg;

    logic signed [ANGLE_W-1:0]    angle_reg;
    logic                         dir_reg;
    logic [COUNT_W-1:0]           count_reg;
    logic [SUM_W-1:0]             rsum_reg;
    logic signed [SUM_W-1:0]      asum_reg;
    logic [HIT_W-1:0]             hit_reg;
    logic [IDX_W-1:0]             idx_reg;

    logic [RANGE_W-1:0]           base_mem [STORE_DEPTH];
    logic [RANGE_W-1:0]           base_rd_reg;

    logic signed [ANGLE_W-1:0]    res_ang_reg;
    logic [RANGE_W-1:0]           res_dist_reg;
    logic                         res_seen_reg;
    logic                         res_bad_reg;
    logic                         res_done_reg;
    logic signed [ANGLE_W-1:0]    res_avga_reg;
    logic [RANGE_W-1:0]           res_avgr_reg;
    logic                         res_none_reg;

    logic signed [ANGLE_W-1:0]    out_ang_reg;
    logic [RANGE_W-1:0]           out_dist_reg;
    logic                         out_seen_reg;
    logic                         out_bad_reg;
    logic                         out_done_reg;
    logic signed [ANGLE_W-1:0]    out_avga_reg;
    logic [RANGE_W-1:0]           out_avgr_reg;
    logic                         out_none_reg;

    logic signed [OFS_W-1:0]      ofs;
    logic [IDX_W-1:0]             idx_calc;
    logic                         bad;
    logic [RANGE_W-1:0]           range_calc;
    logic                         seen;
    logic                         cal_end;
    logic                         det_end;
    logic [SUM_W-1:0]             amag;
    logic                         div_start;
    logic [DVD_W-1:0]             div_dividend;
    logic [DVS_W-1:0]             div_divisor;
    logic                         div_done;
    logic [DVD_W-1:0]             div_quo;

    always_comb
    begin
        ofs = OFS_W'(angle_reg) + OFS_HALF;
        if (ofs < 0)
        begin
            idx_calc = '0;
        end
        else if (ofs > OFS_TOP)
        begin
            idx_calc = IDX_W'(2 * HALF_SPAN);
        end
        else
        begin
            idx_calc = ofs[IDX_W-1:0];
        end

        bad = (sample_reg == '0);
        if (bad || (div_quo >= DVD_W'(maxd_reg)))
        begin
            range_calc = maxd_reg;
        end
        else
        begin
            range_calc = div_quo[RANGE_W-1:0];
        end

        seen    = mode_reg && (base_rd_reg > range_calc)
                  && ((base_rd_reg - range_calc) > thr_reg);
        cal_end = !mode_reg && (count_reg >= CAL_END);
        det_end = mode_reg && (count_reg >= DET_END);
        amag    = asum_reg[SUM_W-1] ? SUM_W'(-asum_reg) : SUM_W'(asum_reg);

        div_start = cmd.conv_start || cmd.ang_start || cmd.rng_start;
        if (cmd.ang_start)
        begin
            div_dividend = amag;
            div_divisor  = DVS_W'(hit_reg);
        end
        else if (cmd.rng_start)
        begin
            div_dividend = rsum_reg;
            div_divisor  = DVS_W'(hit_reg);
        end
        else
        begin
            div_dividend = DVD_W'(scale_reg);
            div_divisor  = DVS_W'(sample_reg);
        end

        status.div_done = div_done;
        status.need_avg = det_end && (hit_reg != '0);
    end

    sbol_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= sbol_pkg::RST_THRESHOLD;
            maxd_reg  <= sbol_pkg::RST_MAX_DIST;
            scale_reg <= sbol_pkg::RST_SCALE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                sbol_pkg::REG_THRESHOLD: thr_reg   <= cfg_wdata[sbol_pkg::THR_W-1:0];
                sbol_pkg::REG_MAX_DIST:  maxd_reg  <= cfg_wdata[RANGE_W-1:0];
                sbol_pkg::REG_SCALE:     scale_reg <= cfg_wdata[sbol_pkg::SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= ANG_MIN;
            dir_reg   <= 1'b1;
            count_reg <= '0;
            rsum_reg  <= '0;
            asum_reg  <= '0;
            hit_reg   <= '0;
        end
        else if (cmd.capture)
        begin
            if (start_sweep)
            begin
                angle_reg <= ANG_MIN;
                count_reg <= '0;
                rsum_reg  <= '0;
                asum_reg  <= '0;
                hit_reg   <= '0;
            end
        end
        else if (cmd.conv_start)
        begin
            if (angle_reg >= ANG_MAX)
            begin
                dir_reg <= 1'b0;
            end
            else if (angle_reg <= ANG_MIN)
            begin
                dir_reg <= 1'b1;
            end
        end
        else if (cmd.eval)
        begin
            angle_reg <= dir_reg ? angle_reg + ANGLE_W'(1) : angle_reg - ANGLE_W'(1);
            count_reg <= count_reg + COUNT_W'(1);
            if (seen)
            begin
                rsum_reg <= rsum_reg + SUM_W'(range_calc);
                asum_reg <= asum_reg + SUM_W'(angle_reg);
                hit_reg  <= hit_reg + HIT_W'(1);
            end
        end
        else if (cmd.end_check)
        begin
            if (cal_end)
            begin
                angle_reg <= '0;
                count_reg <= '0;
            end
            else if (det_end && (hit_reg == '0))
            begin
                count_reg <= '0;
                rsum_reg  <= '0;
                asum_reg  <= '0;
                hit_reg   <= '0;
            end
        end
        else if (cmd.rng_take)
        begin
            count_reg <= '0;
            rsum_reg  <= '0;
            asum_reg  <= '0;
            hit_reg   <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= mode;
            sample_reg <= sample;
        end
        if (cmd.conv_start)
        begin
            idx_reg <= idx_calc;
        end
        if (cmd.eval && !mode_reg)
        begin
            base_mem[idx_reg] <= range_calc;
        end
        base_rd_reg <= base_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            res_ang_reg  <= angle_reg;
            res_dist_reg <= range_calc;
            res_seen_reg <= seen;
            res_bad_reg  <= bad;
            res_done_reg <= 1'b0;
            res_avga_reg <= '0;
            res_avgr_reg <= '0;
            res_none_reg <= 1'b0;
        end
        if (cmd.end_check)
        begin
            res_done_reg <= cal_end || det_end;
            res_none_reg <= det_end && (hit_reg == '0);
        end
        if (cmd.ang_take)
        begin
            res_avga_reg <= asum_reg[SUM_W-1] ? -div_quo[ANGLE_W-1:0] : div_quo[ANGLE_W-1:0];
        end
        if (cmd.rng_take)
        begin
            res_avgr_reg <= div_quo[RANGE_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_ang_reg  <= res_ang_reg;
            out_dist_reg <= res_dist_reg;
            out_seen_reg <= res_seen_reg;
            out_bad_reg  <= res_bad_reg;
            out_done_reg <= res_done_reg;
            out_avga_reg <= res_avga_reg;
            out_avgr_reg <= res_avgr_reg;
            out_none_reg <= res_none_reg;
        end
    end

    assign motor_angle = out_ang_reg;
    assign range_value = out_dist_reg;
    assign object_seen = out_seen_reg;
    assign bad_sample  = out_bad_reg;
    assign sweep_done  = out_done_reg;
    assign avg_angle   = out_avga_reg;
    assign avg_range   = out_avgr_reg;
    assign none_found  = out_none_reg;

endmodule

FILE: rtl/sbol_controller.sv
// ----------------------------------------------------------------------------
// Sweep baseline object locator controller
// Sequences one transaction through conversion, evaluation and, when a detect sweep ends with hits, averaging.
// ----------------------------------------------------------------------------
module sbol_controller
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  sbol_pkg::status_t status,
    output sbol_pkg::cmd_t    cmd
);

    sbol_pkg::state_t state_reg;
    sbol_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbol_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            sbol_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sbol_pkg::ST_CONV;
                end
            end
            sbol_pkg::ST_CONV:
            begin
                cmd.conv_start = 1'b1;
                state_next     = sbol_pkg::ST_CONV_WAIT;
            end
            sbol_pkg::ST_CONV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = sbol_pkg::ST_EVAL;
                end
            end
            sbol_pkg::ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sbol_pkg::ST_END;
            end
            sbol_pkg::ST_END:
            begin
                cmd.end_check = 1'b1;
                state_next    = status.need_avg ? sbol_pkg::ST_AVGA : sbol_pkg::ST_FIN;
            end
            sbol_pkg::ST_AVGA:
            begin
                cmd.ang_start = 1'b1;
                state_next    = sbol_pkg::ST_AVGA_WAIT;
            end
            sbol_pkg::ST_AVGA_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.ang_take = 1'b1;
                    state_next   = sbol_pkg::ST_AVGR;
                end
            end
            sbol_pkg::ST_AVGR:
            begin
                cmd.rng_start = 1'b1;
                state_next    = sbol_pkg::ST_AVGR_WAIT;
            end
            sbol_pkg::ST_AVGR_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.rng_take = 1'b1;
                    state_next   = sbol_pkg::ST_FIN;
                end
            end
            sbol_pkg::ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = sbol_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbol_pkg::ST_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/sweep_baseline_object_locator.sv
// ----------------------------------------------------------------------------
// Sweep baseline object locator
// Converts each sample to a distance, tracks the sweep angle, keeps a
// baseline per angle and reports hits and their averages.
// A new transaction is accepted only once the last result has been loaded
// into the output registers; the serial divider, one quotient bit per cycle
// over 24 bits, performs the conversion and both averages.
// Reset: asynchronous; configuration, angle, direction, counters, sums,
// controller state and out_valid take their reset values; the sample, result
// and output registers and the baseline memory are left as they are.
// ----------------------------------------------------------------------------
module sweep_baseline_object_locator
#(
    parameter int HALF_SPAN       = sbol_pkg::DEF_HALF_SPAN,
    parameter int CALIBRATE_STEPS = sbol_pkg::DEF_CALIBRATE_STEPS,
    parameter int DETECT_STEPS    = sbol_pkg::DEF_DETECT_STEPS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [sbol_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sbol_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  mode,
    input  logic                                  start_sweep,
    input  logic [sbol_pkg::SAMPLE_W-1:0]         sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [sbol_pkg::ANGLE_W-1:0]   motor_angle,
    output logic [sbol_pkg::RANGE_W-1:0]          range_value,
    output logic                                  object_seen,
    output logic                                  bad_sample,
    output logic                                  sweep_done,
    output logic signed [sbol_pkg::ANGLE_W-1:0]   avg_angle,
    output logic [sbol_pkg::RANGE_W-1:0]          avg_range,
    output logic                                  none_found
);

    sbol_pkg::cmd_t    cmd;
    sbol_pkg::status_t status;

    sbol_controller u_controller
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sbol_datapath
    #(
        .HALF_SPAN       (HALF_SPAN),
        .CALIBRATE_STEPS (CALIBRATE_STEPS),
        .DETECT_STEPS    (DETECT_STEPS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mode        (mode),
        .start_sweep (start_sweep),
        .sample      (sample),
        .cmd         (cmd),
        .status      (status),
        .motor_angle (motor_angle),
        .range_value (range_value),
        .object_seen (object_seen),
        .bad_sample  (bad_sample),
        .sweep_done  (sweep_done),
        .avg_angle   (avg_angle),
        .avg_range   (avg_range),
        .none_found  (none_found)
    );

endmodule

FILE: test/tb_sweep_baseline_object_locator.sv
// ----------------------------------------------------------------------------
// Testbench for the sweep baseline object locator
// Drives calibrate and detect steps through the valid/ready input channel,
// predicts every step from its own model of the angle, baseline and hit
// averaging, and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module tb_sweep_baseline_object_locator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int   ANGLE_W       = sbol_pkg::ANGLE_W;
    localparam int   RANGE_W       = sbol_pkg::RANGE_W;
    localparam int   SAMPLE_W      = sbol_pkg::SAMPLE_W;
    localparam int   CFG_W         = sbol_pkg::CFG_W;
    localparam int   CFG_IDX_W     = sbol_pkg::CFG_IDX_W;
    localparam int   HALF          = sbol_pkg::DEF_HALF_SPAN;
    localparam int   CAL_STEPS     = sbol_pkg::DEF_CALIBRATE_STEPS;
    localparam int   DET_STEPS     = sbol_pkg::DEF_DETECT_STEPS;
    localparam int   SPAN          = 2 * HALF + 1;
    localparam logic MODE_CALIBRATE = 1'b0;
    localparam logic MODE_DETECT    = 1'b1;
    localparam int   CYCLE_LIMIT   = 1_000_000;
    localparam int   SETTLE_CYCLES = 200;
    localparam int   LEAD_CALIBRATE = 60;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] motor_angle;
        logic [RANGE_W-1:0]        range_value;
        logic                      object_seen;
        logic                      bad_sample;
        logic                      sweep_done;
        logic signed [ANGLE_W-1:0] avg_angle;
        logic [RANGE_W-1:0]        avg_range;
        logic                      none_found;
    } step_result_t;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index   = sbol_pkg::REG_THRESHOLD;
    logic [CFG_W-1:0]             cfg_wdata   = '0;
    logic                         in_valid    = 1'b0;
    logic                         in_ready;
    logic                         mode        = MODE_CALIBRATE;
    logic                         start_sweep = 1'b0;
    logic [SAMPLE_W-1:0]          sample      = '0;
    logic                         out_valid;
    logic                         out_ready   = 1'b0;
    logic signed [ANGLE_W-1:0]    motor_angle;
    logic [RANGE_W-1:0]           range_value;
    logic                         object_seen;
    logic                         bad_sample;
    logic                         sweep_done;
    logic signed [ANGLE_W-1:0]    avg_angle;
    logic [RANGE_W-1:0]           avg_range;
    logic                         none_found;

    // Model of the locator state and its registers.
    int unsigned        cfg_thr   = sbol_pkg::RST_THRESHOLD;
    int unsigned        cfg_max   = sbol_pkg::RST_MAX_DIST;
    int unsigned        cfg_scale = sbol_pkg::RST_SCALE;
    int                 loc_angle = -HALF;
    int                 loc_dir   = 1;
    logic [RANGE_W-1:0] baseline_ref [SPAN];
    bit                 baseline_written [SPAN];
    int unsigned        loc_steps  = 0;
    int unsigned        hit_range_sum = 0;
    int                 hit_angle_sum = 0;
    int unsigned        hit_total  = 0;

    step_result_t step_results_due [$];

    bit valid_on        = 1'b0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;
    int settings_used   = 1;
    int detect_ends_hits = 0;
    int detect_ends_none = 0;
    int calibrate_ends  = 0;

    sweep_baseline_object_locator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .start_sweep (start_sweep),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .motor_angle (motor_angle),
        .range_value (range_value),
        .object_seen (object_seen),
        .bad_sample  (bad_sample),
        .sweep_done  (sweep_done),
        .avg_angle   (avg_angle),
        .avg_range   (avg_range),
        .none_found  (none_found)
    );

    always #1 clk = ~clk;

    function automatic step_result_t compute_step_result(input logic md, input logic st,
                                                         input logic [SAMPLE_W-1:0] smp);
        step_result_t r;
        int           ang;
        int           idx;
        int unsigned  range_est;
        int unsigned  quot;
        int unsigned  base;
        int unsigned  mag;
        r = '0;
        if (st)
        begin
            loc_angle     = -HALF;
            loc_steps     = 0;
            hit_range_sum = 0;
            hit_angle_sum = 0;
            hit_total     = 0;
        end
        ang = loc_angle;
        if (ang >= HALF)
            loc_dir = -1;
        else if (ang <= -HALF)
            loc_dir = 1;
        if (smp == 0)
        begin
            r.bad_sample = 1'b1;
            range_est = cfg_max;
        end
        else
        begin
            quot = cfg_scale / smp;
            range_est = (quot >= cfg_max) ? cfg_max : quot;
        end
        idx = ang + HALF;
        if (idx < 0)
            idx = 0;
        if (idx > 2 * HALF)
            idx = 2 * HALF;
        if (md == MODE_CALIBRATE)
        begin
            baseline_ref[idx]     = range_est[RANGE_W-1:0];
            baseline_written[idx] = 1'b1;
        end
        else
        begin
            base = baseline_ref[idx];
            if (base > range_est && base - range_est > cfg_thr)
            begin
                r.object_seen = 1'b1;
                hit_range_sum += range_est;
                hit_angle_sum += ang;
                hit_total++;
            end
        end
        loc_angle = ang + loc_dir;
        loc_steps++;
        if (md == MODE_CALIBRATE)
        begin
            if (loc_steps >= CAL_STEPS)
            begin
                r.sweep_done = 1'b1;
                loc_angle    = 0;
                loc_steps    = 0;
                calibrate_ends++;
            end
        end
        else if (loc_steps >= DET_STEPS)
        begin
            r.sweep_done = 1'b1;
            if (hit_total == 0)
            begin
                r.none_found = 1'b1;
                detect_ends_none++;
            end
            else
            begin
                mag = (hit_angle_sum < 0) ? -hit_angle_sum : hit_angle_sum;
                quot = mag / hit_total;
                r.avg_angle = (hit_angle_sum < 0) ? -quot[ANGLE_W-1:0] : quot[ANGLE_W-1:0];
                quot = hit_range_sum / hit_total;
                r.avg_range = quot[RANGE_W-1:0];
                detect_ends_hits++;
            end
            loc_steps     = 0;
            hit_range_sum = 0;
            hit_angle_sum = 0;
            hit_total     = 0;
        end
        r.motor_angle = ang[ANGLE_W-1:0];
        r.range_value = range_est[RANGE_W-1:0];
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int c;
        c = $urandom_range(0, 19);
        if (c == 0)
            return '0;
        else if (c < 7)
            return SAMPLE_W'($urandom_range(1, 600));
        return SAMPLE_W'($urandom_range(0, 4095));
    endfunction

    task automatic send_step(input logic md, input logic st, input logic [SAMPLE_W-1:0] smp);
        logic use_mode;
        int   next_angle;
        use_mode   = md;
        next_angle = st ? -HALF : loc_angle;
        // A detect step must only read a baseline entry that has been written.
        if (use_mode == MODE_DETECT && !baseline_written[next_angle + HALF])
            use_mode = MODE_CALIBRATE;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            if (valid_on)
            begin
                in_valid <= 1'b0;
                valid_on = 1'b0;
            end
            @(posedge clk);
        end
        mode        <= use_mode;
        start_sweep <= st;
        sample      <= smp;
        if (!valid_on)
        begin
            in_valid <= 1'b1;
            valid_on = 1'b1;
        end
        do
            @(posedge clk);
        while (!in_ready);
        step_results_due.push_back(compute_step_result(use_mode, st, smp));
        items_sent++;
    endtask

    task automatic wait_for_results();
        if (valid_on)
        begin
            in_valid <= 1'b0;
            valid_on = 1'b0;
        end
        while (step_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input int unsigned thr, input int unsigned maxd,
                              input int unsigned scale);
        wait_for_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= sbol_pkg::REG_THRESHOLD;
        cfg_wdata <= CFG_W'(thr);
        @(posedge clk);
        cfg_index <= sbol_pkg::REG_MAX_DIST;
        cfg_wdata <= CFG_W'(maxd);
        @(posedge clk);
        cfg_index <= sbol_pkg::REG_SCALE;
        cfg_wdata <= CFG_W'(scale);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_thr   = thr;
        cfg_max   = maxd;
        cfg_scale = scale;
        settings_used++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Mismatch in %s at result transaction %0d: expected %0d, got %0d",
                         name, results_checked, want, got);
        end
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_results
        step_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (step_results_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Result transaction %0d arrived with nothing expected",
                             results_checked);
            end
            else
            begin
                want = step_results_due.pop_front();
                check_field("motor_angle", $signed(want.motor_angle), $signed(motor_angle));
                check_field("range_value", want.range_value, range_value);
                check_field("object_seen", want.object_seen, object_seen);
                check_field("bad_sample", want.bad_sample, bad_sample);
                check_field("sweep_done", want.sweep_done, sweep_done);
                check_field("avg_angle", $signed(want.avg_angle), $signed(avg_angle));
                check_field("avg_range", want.avg_range, avg_range);
                check_field("none_found", want.none_found, none_found);
            end
            results_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out with %0d results still outstanding",
                     step_results_due.size());
            $display("tb_sweep_baseline_object_locator failed");
            $finish;
        end
    end

    // Conversion edges under the reset registers, then detect steps on those angles.
    task automatic test_conversion_edges();
        send_step(MODE_CALIBRATE, 1'b1, 12'd0);
        send_step(MODE_CALIBRATE, 1'b0, 12'd1);
        send_step(MODE_CALIBRATE, 1'b0, 12'd4095);
        send_step(MODE_CALIBRATE, 1'b0, 12'd517);
        send_step(MODE_CALIBRATE, 1'b0, 12'd516);
        send_step(MODE_DETECT, 1'b1, 12'd4095);
        send_step(MODE_DETECT, 1'b0, 12'd0);
        send_step(MODE_DETECT, 1'b0, 12'd4095);
        send_step(MODE_DETECT, 1'b0, 12'd651);
        send_step(MODE_DETECT, 1'b0, 12'd656);
    endtask

    // A full calibrate sweep passes both turning points and writes every baseline entry.
    task automatic test_calibrate_sweep();
        for (int i = 0; i < CAL_STEPS; i++)
            send_step(MODE_CALIBRATE, i == 0,
                      ($urandom_range(0, 24) == 0) ? '0 : SAMPLE_W'($urandom_range(1, 516)));
    endtask

    // Hits only on the negative half, so the mean angle is negative and truncated.
    task automatic test_detect_average();
        for (int i = 0; i < DET_STEPS; i++)
        begin
            if (i == DET_STEPS / 2)
                wait_for_results();
            send_step(MODE_DETECT, i == 0,
                      (i < HALF) ? 12'd4095 : SAMPLE_W'($urandom_range(1, 516)));
        end
    endtask

    // Calibrate steps open the sweep and detect steps finish the shared count without a hit.
    task automatic test_no_hits();
        set_config(255, 255, 131071);
        for (int i = 0; i < DET_STEPS; i++)
            send_step((i < LEAD_CALIBRATE) ? MODE_CALIBRATE : MODE_DETECT, i == 0,
                      pick_sample());
    endtask

    task automatic test_small_limits();
        set_config(0, 1, 1);
        for (int i = 0; i < 24; i++)
            send_step($urandom_range(0, 1) == 1, (i == 0) || ($urandom_range(0, 9) == 0),
                      pick_sample());
    endtask

    initial
    begin
        send_idle_pct = 12;
        recv_idle_pct = 61;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_conversion_edges();
        test_calibrate_sweep();
        send_idle_pct = 61;
        recv_idle_pct = 12;
        test_detect_average();
        test_small_limits();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_no_hits();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Checked %0d results from %0d steps over %0d register settings.",
                 results_checked, items_sent, settings_used);
        $display("Sweep ends seen: %0d detect with hits, %0d detect empty, %0d calibrate.",
                 detect_ends_hits, detect_ends_none, calibrate_ends);
        if (mismatch_count == 0)
            $display("tb_sweep_baseline_object_locator passed");
        else
            $display("tb_sweep_baseline_object_locator failed");
        $finish;
    end

endmodule
